// ----- sv/bcw_pkg.sv -----
package bcw_pkg;

  localparam int unsigned ATOM_W     = 6;
  localparam int unsigned ATOM_SPACE = 64;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned ANS_W      = 7;

  localparam logic [ANS_W-1:0] ANS_MAX = 7'h7f;

  localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_COUNT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BRANCH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_RD_A,
    ST_WR_MOD_A,
    ST_WR_RD_B,
    ST_WR_MOD_B,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              found;
    logic [ATOM_W-1:0] idx;
  } step_res_t;

endpackage

// ----- sv/bcw_ram.sv -----
module bcw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- sv/bcw_step_unit.sv -----
module bcw_step_unit
  import bcw_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH-1:0]  row_i,
  input  logic [ATOM_W-1:0] cur_i,
  output step_res_t         res_o
);

  // highest set bit strictly below the current atom (diagonal excluded)
  always_comb begin
    res_o = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (row_i[i] && (ATOM_W'(i) < cur_i)) begin
        res_o.found = 1'b1;
        res_o.idx   = ATOM_W'(i);
      end
    end
  end

endmodule

// ----- sv/bond_chain_walk_engine.sv -----
// Bond chain walk engine. Holds a symmetric bond matrix, one row per atom in a
// row memory, and runs writes, path counts and branch searches on one item at
// a time; in_stall_o stays high from the accepted transfer until the result
// is in the output register, and a new item is taken while that result still
// waits. A write does a read-modify-write of both rows. Each walk step, and
// each failed step that finds no lower bond, is one row read from the memory,
// then one priority encode in the shared step unit. A count query walks both
// legs, one row read per step; a branch query walks from every candidate
// tried, so its row reads grow with the square of the atom span. Rows carry
// valid bits cleared at reset, so there is no clearing pass and an unwritten
// row reads as no bonds.
module bond_chain_walk_engine
  import bcw_pkg::*;
#(
  parameter int unsigned ATOM_COUNT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [ATOM_W-1:0] atom_first_i,
  input  logic [ATOM_W-1:0] atom_second_i,
  input  logic              bond_bit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ANS_W-1:0]  answer_o,
  output logic              stuck_o
);

  // only atoms reachable through the 6-bit fields need storage
  localparam int unsigned ROWS   = (ATOM_COUNT < ATOM_SPACE) ? ATOM_COUNT : ATOM_SPACE;
  localparam int unsigned ROW_AW = $clog2(ROWS);
  localparam logic [ATOM_W:0] ROWS_LIM = (ATOM_W + 1)'(ROWS);

  state_e state_q, state_d;

  logic [ACT_W-1:0]  act_q, act_d;
  logic [ATOM_W-1:0] a_q, a_d;
  logic [ATOM_W-1:0] b_q, b_d;
  logic              bit_q, bit_d;
  logic [ATOM_W-1:0] cur_q, cur_d;
  logic [ATOM_W-1:0] limit_q, limit_d;
  logic [ATOM_W-1:0] cand_q, cand_d;
  logic [ATOM_W-1:0] rd_addr_q, rd_addr_d;
  logic              phase_q, phase_d;
  logic [ANS_W-1:0]  steps_q, steps_d;
  logic [ANS_W-1:0]  answer_q, answer_d;
  logic              stuck_q, stuck_d;
  logic [ROWS-1:0]   row_valid_q, row_valid_d;

  logic              out_valid_q, out_valid_d;
  logic [ANS_W-1:0]  out_answer_q, out_answer_d;
  logic              out_stuck_q, out_stuck_d;

  logic              ram_wr_en;
  logic [ROW_AW-1:0] ram_wr_addr;
  logic [ROWS-1:0]   ram_wr_data;
  logic              ram_rd_en;
  logic [ROW_AW-1:0] ram_rd_addr;
  logic [ROWS-1:0]   ram_rd_data;

  logic [ROWS-1:0]   row_eff;
  logic              rd_in_range;
  step_res_t         step_res;
  logic [ATOM_W-1:0] landed;
  logic              walk_end;
  logic [ATOM_W-1:0] cand_dec;

  bcw_ram #(
    .WIDTH (ROWS),
    .DEPTH (ROWS)
  ) u_rows (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // unwritten or out-of-range rows read as no bonds
  assign rd_in_range = ({1'b0, rd_addr_q} < ROWS_LIM);
  assign row_eff = (rd_in_range && row_valid_q[rd_addr_q[ROW_AW-1:0]]) ? ram_rd_data : '0;
  assign cand_dec = cand_q - 1'b1;

  bcw_step_unit #(
    .WIDTH (ROWS)
  ) u_step (
    .row_i (row_eff),
    .cur_i (cur_q),
    .res_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    a_q          <= a_d;
    b_q          <= b_d;
    bit_q        <= bit_d;
    cur_q        <= cur_d;
    limit_q      <= limit_d;
    cand_q       <= cand_d;
    rd_addr_q    <= rd_addr_d;
    phase_q      <= phase_d;
    steps_q      <= steps_d;
    answer_q     <= answer_d;
    stuck_q      <= stuck_d;
    out_answer_q <= out_answer_d;
    out_stuck_q  <= out_stuck_d;
  end

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    a_d          = a_q;
    b_d          = b_q;
    bit_d        = bit_q;
    cur_d        = cur_q;
    limit_d      = limit_q;
    cand_d       = cand_q;
    rd_addr_d    = rd_addr_q;
    phase_d      = phase_q;
    steps_d      = steps_q;
    answer_d     = answer_q;
    stuck_d      = stuck_q;
    row_valid_d  = row_valid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_answer_d = out_answer_q;
    out_stuck_d  = out_stuck_q;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = a_q[ROW_AW-1:0];
    ram_wr_data  = row_eff;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = cur_q[ROW_AW-1:0];
    landed       = cur_q;
    walk_end     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d    = action_i;
          a_d      = atom_first_i;
          b_d      = atom_second_i;
          bit_d    = bond_bit_i;
          phase_d  = 1'b0;
          steps_d  = '0;
          answer_d = '0;
          stuck_d  = 1'b0;
          state_d  = ST_DONE;
          case (action_i)
            ACT_WRITE: begin
              if (({1'b0, atom_first_i} < ROWS_LIM) && ({1'b0, atom_second_i} < ROWS_LIM)) begin
                state_d = ST_WR_RD_A;
              end
            end
            ACT_COUNT: begin
              if (atom_first_i != atom_second_i) begin
                cur_d   = (atom_first_i > atom_second_i) ? atom_first_i : atom_second_i;
                limit_d = (atom_first_i > atom_second_i) ? atom_second_i : atom_first_i;
                state_d = ST_WALK_RD;
              end
            end
            ACT_BRANCH: begin
              answer_d = {1'b0, atom_second_i};
              if (atom_first_i > atom_second_i) begin
                cur_d   = atom_first_i;
                cand_d  = atom_first_i;
                limit_d = atom_second_i;
                state_d = ST_WALK_RD;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_WR_RD_A: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = a_q[ROW_AW-1:0];
        rd_addr_d   = a_q;
        state_d     = ST_WR_MOD_A;
      end

      ST_WR_MOD_A: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = a_q[ROW_AW-1:0];
        ram_wr_data[b_q[ROW_AW-1:0]] = bit_q;
        row_valid_d[a_q[ROW_AW-1:0]] = 1'b1;
        state_d     = ST_WR_RD_B;
      end

      ST_WR_RD_B: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = b_q[ROW_AW-1:0];
        rd_addr_d   = b_q;
        state_d     = ST_WR_MOD_B;
      end

      ST_WR_MOD_B: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = b_q[ROW_AW-1:0];
        ram_wr_data[a_q[ROW_AW-1:0]] = bit_q;
        row_valid_d[b_q[ROW_AW-1:0]] = 1'b1;
        state_d     = ST_DONE;
      end

      ST_WALK_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = cur_q[ROW_AW-1:0];
        rd_addr_d   = cur_q;
        state_d     = ST_WALK_EV;
      end

      ST_WALK_EV: begin
        if (step_res.found) begin
          cur_d  = step_res.idx;
          landed = step_res.idx;
          if ((act_q == ACT_COUNT) && (steps_q != ANS_MAX)) begin
            steps_d = steps_q + 1'b1;
          end
          if (step_res.idx > limit_q) begin
            state_d = ST_WALK_RD;
          end else begin
            walk_end = 1'b1;
          end
        end else begin
          stuck_d  = 1'b1;
          walk_end = 1'b1;
        end

        if (walk_end) begin
          state_d = ST_DONE;
          if (act_q == ACT_COUNT) begin
            // second leg: from the smaller atom down to the meeting point
            if (!phase_q) begin
              phase_d = 1'b1;
              cur_d   = limit_q;
              limit_d = landed;
              if (limit_q > landed) begin
                state_d = ST_WALK_RD;
              end
            end
          end else begin
            if (landed == b_q) begin
              answer_d = {1'b0, cand_q};
            end else if (cand_dec > b_q) begin
              cand_d  = cand_dec;
              cur_d   = cand_dec;
              state_d = ST_WALK_RD;
            end
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_answer_d = (act_q == ACT_COUNT) ? steps_q : answer_q;
          out_stuck_d  = stuck_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign answer_o    = out_answer_q;
  assign stuck_o     = out_stuck_q;

endmodule

// ----- sv/bcw_checker.sv -----
module bcw_checker
  import bcw_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [ACT_W-1:0]  action_i,
  input logic [ATOM_W-1:0] atom_first_i,
  input logic [ATOM_W-1:0] atom_second_i,
  input logic              bond_bit_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ANS_W-1:0]  answer_o,
  input logic              stuck_o
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(answer_o) && $stable(stuck_o))
    else $error("stalled result changed");

  // one item at a time: an accepted transfer makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting an item");

  // going idle means a result was loaded into a free output slot
  a_idle_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && $past(!out_valid_o || !out_stall_i))
    else $error("block went idle without delivering a result");

  // a fresh result only appears after the block was busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in work");

endmodule

bind bond_chain_walk_engine bcw_checker u_bcw_checker (.*);
